FILE: hw/rtl/write_back_cache_add_controller_defines.svh
// Assertion macros shared by the cache add controller RTL.
`ifndef WRITE_BACK_CACHE_ADD_CONTROLLER_DEFINES_SVH
`define WRITE_BACK_CACHE_ADD_CONTROLLER_DEFINES_SVH

// Clocked assertion that is off while reset is asserted.
`define WBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that a condition never holds.
`define WBC_ASSERT_NEVER(label, cond, msg) \
  `WBC_ASSERT(label, !(cond), msg)

`endif

FILE: hw/rtl/wbc_pkg.sv
// Package with constants and types of the cache add controller.
package wbc_pkg;

  localparam int unsigned Lines = 4096;
  localparam int unsigned IdxW  = $clog2(Lines);
  localparam int unsigned AddrW = 32;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_LOAD_RSP = 2'd1;
  localparam logic [1:0] CMD_STORE_ACK = 2'd2;
  localparam logic [1:0] CMD_DONE     = 2'd3;

  localparam logic [1:0] KIND_LOAD       = 2'd0;
  localparam logic [1:0] KIND_STORE      = 2'd1;
  localparam logic [1:0] KIND_ADD_DONE   = 2'd2;
  localparam logic [1:0] KIND_FLUSH_DONE = 2'd3;

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_A     = 3'd1;
  localparam logic [2:0] P_B     = 3'd2;
  localparam logic [2:0] P_DEST  = 3'd3;
  localparam logic [2:0] P_FLUSH = 3'd4;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [AddrW-1:0] tag;
    logic [DataW-1:0] data;
  } line_t;

endpackage

FILE: hw/rtl/wbc_intf.sv
// Valid/ready channel interfaces for commands and replies of the controller.
interface wbc_cmd_if import wbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [AddrW-1:0]        src_addr_a;
  logic [AddrW-1:0]        src_addr_b;
  logic [AddrW-1:0]        dest_addr;
  logic signed [DataW-1:0] load_data;

  modport source (output valid, command, src_addr_a, src_addr_b, dest_addr, load_data,
                  input ready);
  modport sink (input valid, command, src_addr_a, src_addr_b, dest_addr, load_data,
                output ready);
endinterface

interface wbc_rsp_if import wbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              reply_kind;
  logic [AddrW-1:0]        mem_addr;
  logic signed [DataW-1:0] store_data;

  modport source (output valid, reply_kind, mem_addr, store_data, input ready);
  modport sink (input valid, reply_kind, mem_addr, store_data, output ready);
endinterface

FILE: hw/rtl/wbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/write_back_cache_add_controller.sv
// Direct-mapped write-back cache controller for memory-to-memory adds.
// Each address check has two steps: line read in S_LOOKUP, then tag compare and write-back in S_CHECK.
// A transaction replies at its first miss or at the destination; each operand hit first adds one more check.
// A flush scans the lines in order with S_SCAN and S_SCHK, up to all 4096 lines of the cache.
// After reset a clearing pass zeroes all 4096 lines of the line memory; no command is taken then.
// The line memory takes one read and one write per cycle.
`include "write_back_cache_add_controller_defines.svh"

module write_back_cache_add_controller import wbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wbc_cmd_if.sink   cmd_i,
  wbc_rsp_if.source rsp_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SCHK   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic [IdxW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [IdxW-1:0]  flush_ptr_q, flush_ptr_d;
  logic [AddrW-1:0] addr_a_q, addr_a_d, addr_b_q, addr_b_d, dest_q, dest_d;
  logic [DataW-1:0] op_a_q, op_a_d, op_b_q, op_b_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_kind_q, out_kind_d;
  logic [AddrW-1:0] out_addr_q, out_addr_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic             out_load, out_free;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  line_t            ram_wdata, ram_rdata;

  logic [AddrW-1:0] cur_addr;
  logic [IdxW-1:0]  cur_idx;
  logic             hit, accept;
  logic [DataW-1:0] sum;

  wbc_ram #(
    .Width($bits(line_t)),
    .Depth(Lines)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    case (phase_q)
      P_A:     cur_addr = addr_a_q;
      P_B:     cur_addr = addr_b_q;
      default: cur_addr = dest_q;
    endcase
  end

  assign cur_idx       = cur_addr[IdxW-1:0];
  assign hit           = ram_rdata.valid && (ram_rdata.tag == cur_addr);
  assign sum           = op_a_q + op_b_q;
  assign out_free      = !out_valid_q || rsp_o.ready;
  assign cmd_i.ready   = (state_q == S_IDLE);
  assign accept        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    clr_cnt_d   = clr_cnt_q;
    flush_ptr_d = flush_ptr_q;
    addr_a_d    = addr_a_q;
    addr_b_d    = addr_b_q;
    dest_d      = dest_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    out_load    = 1'b0;
    out_kind_d  = out_kind_q;
    out_addr_d  = out_addr_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_idx;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = cur_idx;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IdxW'(Lines - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_ADD, CMD_STORE_ACK: begin
              if (cmd_i.command == CMD_ADD && phase_q == P_IDLE) begin
                addr_a_d = cmd_i.src_addr_a;
                addr_b_d = cmd_i.src_addr_b;
                dest_d   = cmd_i.dest_addr;
                phase_d  = P_A;
                state_d  = S_LOOKUP;
              end else if (phase_q inside {[P_A:P_DEST]}) begin
                state_d = S_LOOKUP;
              end else if (phase_q == P_FLUSH) begin
                state_d = S_SCAN;
              end
            end
            CMD_LOAD_RSP: begin
              if (phase_q inside {[P_A:P_DEST]}) begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b1;
                ram_wdata.dirty = 1'b0;
                ram_wdata.tag   = cur_addr;
                ram_wdata.data  = $unsigned(cmd_i.load_data);
                state_d         = S_LOOKUP;
              end
            end
            default: begin
              phase_d     = P_FLUSH;
              flush_ptr_d = '0;
              state_d     = S_SCAN;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        ram_re  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (hit && phase_q != P_DEST) begin
          if (phase_q == P_A) begin
            op_a_d = ram_rdata.data;
          end else begin
            op_b_d = ram_rdata.data;
          end
          phase_d = phase_q + 3'd1;
          state_d = S_LOOKUP;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (hit) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.dirty = 1'b1;
            ram_wdata.tag   = cur_addr;
            ram_wdata.data  = sum;
            phase_d         = P_IDLE;
            out_kind_d      = KIND_ADD_DONE;
            out_addr_d      = cur_addr;
            out_data_d      = sum;
          end else if (ram_rdata.valid && ram_rdata.dirty) begin
            ram_we          = 1'b1;
            ram_wdata       = ram_rdata;
            ram_wdata.dirty = 1'b0;
            out_kind_d      = KIND_STORE;
            out_addr_d      = ram_rdata.tag;
            out_data_d      = ram_rdata.data;
          end else begin
            out_kind_d = KIND_LOAD;
            out_addr_d = cur_addr;
            out_data_d = '0;
          end
        end
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = flush_ptr_q;
        state_d   = S_SCHK;
      end
      S_SCHK: begin
        if (ram_rdata.valid && ram_rdata.dirty) begin
          if (out_free) begin
            ram_we          = 1'b1;
            ram_waddr       = flush_ptr_q;
            ram_wdata       = ram_rdata;
            ram_wdata.dirty = 1'b0;
            out_load        = 1'b1;
            out_kind_d      = KIND_STORE;
            out_addr_d      = ram_rdata.tag;
            out_data_d      = ram_rdata.data;
            state_d         = S_IDLE;
          end
        end else if (flush_ptr_q == IdxW'(Lines - 1)) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_kind_d  = KIND_FLUSH_DONE;
            out_addr_d  = '0;
            out_data_d  = '0;
            phase_d     = P_IDLE;
            flush_ptr_d = '0;
            state_d     = S_IDLE;
          end
        end else begin
          flush_ptr_d = flush_ptr_q + 1'b1;
          state_d     = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= P_IDLE;
      clr_cnt_q   <= '0;
      flush_ptr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_cnt_q   <= clr_cnt_d;
      flush_ptr_q <= flush_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_a_q   <= addr_a_d;
    addr_b_q   <= addr_b_d;
    dest_q     <= dest_d;
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    out_kind_q <= out_kind_d;
    out_addr_q <= out_addr_d;
    out_data_q <= out_data_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.reply_kind = out_kind_q;
  assign rsp_o.mem_addr   = out_addr_q;
  assign rsp_o.store_data = $signed(out_data_q);

  `WBC_ASSERT(a_check_write_needs_slot,
              (ram_we && (state_q == S_CHECK || state_q == S_SCHK)) |-> out_free,
              "Line written back while the reply register was still occupied.")
  `WBC_ASSERT(a_flush_done_resets,
              (out_load && out_kind_d == KIND_FLUSH_DONE) |=> (phase_q == P_IDLE && flush_ptr_q == '0),
              "Flush completion did not return the controller to idle.")
  `WBC_ASSERT_NEVER(a_no_accept_in_clear,
                    state_q == S_CLEAR && cmd_i.ready,
                    "Transaction accepted during the clearing pass.")

endmodule
